/* sv/lmsd_pkg.sv */
package lmsd_pkg;

  localparam int PANEL_WIDTH_DEF = 64;
  localparam int SCAN_ROWS_DEF   = 8;
  localparam int SEGMENTS_DEF    = 16;

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam int PIX_X_W = 6;
  localparam int PIX_Y_W = 5;
  localparam int COLOR_W = 3;
  localparam int TIME_W  = 32;
  localparam int ROW_SEL_W = 3;

  localparam logic [IN_USER_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [IN_USER_W-1:0] OP_PRESENT = 2'd1;
  localparam logic [IN_USER_W-1:0] OP_STEP    = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] CFG_TEAR     = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_INTERVAL = 1'd1;

  typedef enum logic [OUT_USER_W-1:0] {
    KIND_IDLE  = 2'd0,
    KIND_SHIFT = 2'd1,
    KIND_LATCH = 2'd2
  } kind_t;

endpackage

/* sv/led_matrix_scan_driver_top.sv */
// Channel  Dir  tuser          tdata
// in_      in   opcode[1:0]    pixel_x, pixel_y, pixel_color, now_ms
// out_     out  action_kind    rgb top, rgb bottom, row_select
// cfg_     in   -              cfg_addr 0: tearing enable, 1: frame interval ms
//
// One item per cycle while the output is not stalled and no clearing pass runs; a shift
// result passes the framebuffer read register, then the output register.
// After reset a clearing pass zeroes both frame RAMs, one entry per cycle, over all
// 2*2^clog2(2*SCAN_ROWS)*2^clog2(PANEL_WIDTH) entries of each (2048 by default);
// in_tready stays low meanwhile, cfg writes are taken.
// A stalled output holds one item in the read stage and one in the output register.
module led_matrix_scan_driver_top #(
  parameter int PANEL_WIDTH = lmsd_pkg::PANEL_WIDTH_DEF,
  parameter int SCAN_ROWS   = lmsd_pkg::SCAN_ROWS_DEF,
  parameter int SEGMENTS    = lmsd_pkg::SEGMENTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [5:0] pixel_x, [10:6] pixel_y, [13:11] pixel_color, [45:14] now_ms
  input  logic [lmsd_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] opcode
  input  logic [lmsd_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] red_top, [1] green_top, [2] blue_top, [3] red_bottom,
  // [4] green_bottom, [5] blue_bottom, [8:6] row_select
  output logic [lmsd_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [1:0] action_kind
  output logic [lmsd_pkg::OUT_USER_W-1:0]   out_tuser,
  input  logic                              cfg_we,
  input  logic [lmsd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [lmsd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int WIN_RAW  = PANEL_WIDTH / SEGMENTS;
  localparam int WINDOWS  = (WIN_RAW > 0) ? WIN_RAW : 1;
  localparam int HALF     = 2 * SCAN_ROWS;
  localparam int HEIGHT   = 4 * SCAN_ROWS;
  localparam int XSPAN    = (SEGMENTS * WINDOWS > PANEL_WIDTH) ? SEGMENTS * WINDOWS
                                                               : PANEL_WIDTH;
  localparam int XW       = $clog2(XSPAN + 1);
  localparam int XPW      = $clog2(PANEL_WIDTH);
  localparam int YW       = $clog2(HALF);
  localparam int WW       = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
  localparam int SGW      = $clog2(SEGMENTS + 1);
  localparam int RW       = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;
  localparam int AW       = 1 + YW + XPW;
  localparam int DEPTH    = 1 << AW;
  localparam int CW       = lmsd_pkg::COLOR_W;
  localparam int TW       = lmsd_pkg::TIME_W;

  // input fields
  logic [lmsd_pkg::IN_USER_W-1:0] op;
  logic [lmsd_pkg::PIX_X_W-1:0]   pix_x;
  logic [lmsd_pkg::PIX_Y_W-1:0]   pix_y;
  logic [CW-1:0]                  pix_c;
  logic [TW-1:0]                  now;

  assign op    = in_tuser;
  assign pix_x = in_tdata[5:0];
  assign pix_y = in_tdata[10:6];
  assign pix_c = in_tdata[13:11];
  assign now   = in_tdata[45:14];

  // config
  logic       tear_r;
  logic [7:0] interval_r;

  // scan state
  logic          front_r, front_nxt;
  logic          pend_r, pend_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [SGW-1:0] seg_r, seg_nxt;
  logic          half_r, half_nxt;
  logic [WW-1:0] win_r, win_nxt;
  logic [XW-1:0] xbase_r, xbase_nxt;
  logic [TW-1:0] last_r, last_nxt;

  // clearing pass
  logic          clr_busy_r;
  logic [AW-1:0] clr_addr_r;

  // pipeline
  logic                s1_valid_r;
  lmsd_pkg::kind_t     s1_kind_r;
  logic                s1_blank_r;
  logic [lmsd_pkg::ROW_SEL_W-1:0] s1_row_r;
  logic                out_valid_r;
  lmsd_pkg::kind_t     out_kind_r;
  logic [8:0]          out_bits_r;

  logic out_adv, s1_free, acc;
  assign out_adv   = !out_valid_r || out_tready;
  assign s1_free   = !s1_valid_r || out_adv;
  assign in_tready = !clr_busy_r && s1_free;
  assign acc       = in_tvalid && in_tready;

  // scan decode
  logic          at_start, idle, is_shift, is_step, last_win, block;
  logic [TW-1:0] elapsed;
  logic [XW-1:0] x_sum, x_eff;
  logic          x_off;
  logic [YW-1:0] y_top;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  assign is_step  = acc && (op == lmsd_pkg::OP_STEP);
  assign at_start = (row_r == '0) && (seg_r == '0) && !half_r && (win_r == '0);
  assign elapsed  = now - last_r;
  assign idle     = at_start && (elapsed < TW'(interval_r));
  assign is_shift = (seg_r != SGW'(SEGMENTS));
  assign last_win = (win_r == WW'(WINDOWS - 1));
  assign block    = !half_r;

  always_comb begin
    x_sum = xbase_r + XW'(win_r);
    x_off = 1'b0;
    x_eff = x_sum;
    if (tear_r && block) begin
      if (x_sum == '0) begin
        x_off = 1'b1;
      end else begin
        x_eff = x_sum - XW'(1);
      end
    end
    if (x_eff >= XW'(PANEL_WIDTH)) begin
      x_off = 1'b1;
    end
  end

  assign y_top   = YW'(row_r) + (block ? YW'(SCAN_ROWS) : YW'(0));
  assign rd_addr = {front_r, y_top, x_eff[XPW-1:0]};
  assign rd_en   = is_step && !idle && is_shift;

  // pixel write path
  logic          wr_hit, wr_bot;
  logic [YW-1:0] wr_y;
  logic [AW-1:0] wr_addr, ram_waddr;
  logic [CW-1:0] ram_wdata;
  logic          we_top, we_bot;

  assign wr_hit  = acc && (op == lmsd_pkg::OP_WRITE) && (32'(pix_x) < PANEL_WIDTH)
                   && (32'(pix_y) < HEIGHT);
  assign wr_bot  = (32'(pix_y) >= HALF);
  assign wr_y    = wr_bot ? YW'(32'(pix_y) - HALF) : YW'(pix_y);
  assign wr_addr = {!front_r, wr_y, XPW'(pix_x)};

  assign ram_waddr = clr_busy_r ? clr_addr_r : wr_addr;
  assign ram_wdata = clr_busy_r ? '0 : pix_c;
  assign we_top    = clr_busy_r || (wr_hit && !wr_bot);
  assign we_bot    = clr_busy_r || (wr_hit && wr_bot);

  logic [CW-1:0] top_q, bot_q;

  lmsd_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ram_top (
    .clk   (clk),
    .we    (we_top),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (top_q)
  );

  lmsd_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ram_bot (
    .clk   (clk),
    .we    (we_bot),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (bot_q)
  );

  always_comb begin
    front_nxt = front_r;
    pend_nxt  = pend_r;
    row_nxt   = row_r;
    seg_nxt   = seg_r;
    half_nxt  = half_r;
    win_nxt   = win_r;
    xbase_nxt = xbase_r;
    last_nxt  = last_r;
    if (acc && (op == lmsd_pkg::OP_PRESENT)) begin
      pend_nxt = 1'b1;
    end
    if (is_step && !idle) begin
      if (at_start) begin
        last_nxt = now;
      end
      if (is_shift) begin
        if (last_win) begin
          win_nxt = '0;
          if (half_r) begin
            half_nxt  = 1'b0;
            seg_nxt   = seg_r + SGW'(1);
            xbase_nxt = xbase_r + XW'(WINDOWS);
          end else begin
            half_nxt = 1'b1;
          end
        end else begin
          win_nxt = win_r + WW'(1);
        end
      end else begin
        seg_nxt   = '0;
        xbase_nxt = '0;
        if (row_r == RW'(SCAN_ROWS - 1)) begin
          row_nxt = '0;
          if (pend_r) begin
            front_nxt = !front_r;
            pend_nxt  = 1'b0;
          end
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end
    end
  end

  lmsd_pkg::kind_t step_kind;
  assign step_kind = idle ? lmsd_pkg::KIND_IDLE
                   : (is_shift ? lmsd_pkg::KIND_SHIFT : lmsd_pkg::KIND_LATCH);

  logic [5:0] rgb;
  assign rgb = (s1_kind_r == lmsd_pkg::KIND_SHIFT && !s1_blank_r)
               ? {bot_q[0], bot_q[1], bot_q[2], top_q[0], top_q[1], top_q[2]}
               : 6'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tear_r      <= 1'b0;
      interval_r  <= '0;
      front_r     <= 1'b0;
      pend_r      <= 1'b0;
      row_r       <= '0;
      seg_r       <= '0;
      half_r      <= 1'b0;
      win_r       <= '0;
      xbase_r     <= '0;
      last_r      <= '0;
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == lmsd_pkg::CFG_TEAR) begin
          tear_r <= cfg_wdata[0];
        end
        if (cfg_addr == lmsd_pkg::CFG_INTERVAL) begin
          interval_r <= cfg_wdata;
        end
      end
      front_r <= front_nxt;
      pend_r  <= pend_nxt;
      row_r   <= row_nxt;
      seg_r   <= seg_nxt;
      half_r  <= half_nxt;
      win_r   <= win_nxt;
      xbase_r <= xbase_nxt;
      last_r  <= last_nxt;
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (s1_free) begin
        s1_valid_r <= is_step;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s1_free && is_step) begin
      s1_kind_r  <= step_kind;
      s1_blank_r <= x_off;
      s1_row_r   <= (step_kind == lmsd_pkg::KIND_LATCH) ? lmsd_pkg::ROW_SEL_W'(row_r)
                                                        : '0;
    end
    if (out_adv && s1_valid_r) begin
      out_kind_r <= s1_kind_r;
      out_bits_r <= {s1_row_r, rgb};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {7'd0, out_bits_r};

  a_clear_blocks_read: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !rd_en)
    else $error("framebuffer read during clearing pass");

  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    seg_r <= SGW'(SEGMENTS))
    else $error("segment counter out of range");

  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != lmsd_pkg::KIND_SHIFT) |-> (out_tdata[5:0] == 6'd0))
    else $error("colour bits set on non-shift result");

  a_swap: assert property (@(posedge clk) disable iff (!rst_n)
    is_step && !idle && !is_shift && (row_r == RW'(SCAN_ROWS - 1)) && pend_r
    |=> (front_r != $past(front_r)) && !pend_r)
    else $error("buffer swap missed at end of frame");

endmodule

/* sv/lmsd_ram.sv */
module lmsd_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
